[src/bb3_pkg.sv]
// Shared constants and types for the 3x3 box blur.
// No dependencies; every other file of the block but bb3_ram refers to it by scoped names.
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W = 8;                      // sample width
  localparam int DIM_W = 11;                     // configured size width
  localparam int COL_W = $clog2(MAX_WIDTH);      // column counter
  localparam int ROW_W = $clog2(MAX_HEIGHT);     // row counter
  localparam int SUM_W = 12;                     // nine samples of 255 fit in 12 bits
  localparam int LINE_W = 2 * PIX_W;             // both line stores side by side

  // floor(s / 9) == (s * 3641) >> 15 for every s below 32768
  localparam int DIV9_SHIFT = 15;
  localparam logic [SUM_W-1:0] DIV9_MUL = 12'd3641;

  localparam logic [DIM_W-1:0] MIN_DIM    = 11'd3;
  localparam logic [DIM_W-1:0] DIM_RESET  = 11'd1024;

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_e;

  // status of the pixel being accepted
  typedef struct packed {
    logic produce;   // interior: a result follows
    logic last;      // final interior pixel of the frame
  } pos_t;

endpackage

[src/bb3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the line stores.
module bb3_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bb3_pos.sv]
// Size registers and raster position counters of the 3x3 box blur.
// Depends on bb3_pkg.
module bb3_pos (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bb3_pkg::DIM_W-1:0]    cfg_data_i,
  input  logic                         accept_i,
  output logic [bb3_pkg::COL_W-1:0]    col_o,
  output bb3_pkg::pos_t                pos_o
);

  logic [bb3_pkg::DIM_W-1:0] width_q, height_q;
  logic [bb3_pkg::DIM_W-1:0] width_eff, height_eff;
  logic [bb3_pkg::COL_W-1:0] col_q, col_d;
  logic [bb3_pkg::ROW_W-1:0] row_q, row_d;
  logic                      last_col, last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3_pkg::DIM_RESET;
      height_q <= bb3_pkg::DIM_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bb3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        bb3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // out-of-range sizes act as the nearest legal size
  always_comb begin
    if (width_q < bb3_pkg::MIN_DIM) begin
      width_eff = bb3_pkg::MIN_DIM;
    end else if (width_q > bb3_pkg::DIM_W'(bb3_pkg::MAX_WIDTH)) begin
      width_eff = bb3_pkg::DIM_W'(bb3_pkg::MAX_WIDTH);
    end else begin
      width_eff = width_q;
    end
    if (height_q < bb3_pkg::MIN_DIM) begin
      height_eff = bb3_pkg::MIN_DIM;
    end else if (height_q > bb3_pkg::DIM_W'(bb3_pkg::MAX_HEIGHT)) begin
      height_eff = bb3_pkg::DIM_W'(bb3_pkg::MAX_HEIGHT);
    end else begin
      height_eff = height_q;
    end
  end

  assign last_col = (bb3_pkg::DIM_W'(col_q) + bb3_pkg::DIM_W'(1)) >= width_eff;
  assign last_row = (bb3_pkg::DIM_W'(row_q) + bb3_pkg::DIM_W'(1)) >= height_eff;

  always_comb begin
    col_d = col_q + bb3_pkg::COL_W'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + bb3_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o        = col_q;
  assign pos_o.produce = (col_q >= bb3_pkg::COL_W'(2)) && (row_q >= bb3_pkg::ROW_W'(2));
  assign pos_o.last    = last_col && last_row;

endmodule

[src/bb3_window.sv]
// 3x3 window registers, nine-sample adder and divide-by-nine.
// Depends on bb3_pkg.
module bb3_window (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic [bb3_pkg::PIX_W-1:0] up2_i,
  input  logic [bb3_pkg::PIX_W-1:0] up1_i,
  input  logic [bb3_pkg::PIX_W-1:0] px_i,
  output logic [bb3_pkg::PIX_W-1:0] mean_o
);

  // index 0: two lines up, 1: one line up, 2: current line
  logic [2:0][bb3_pkg::PIX_W-1:0] mid_q, right_q;
  logic [2:0][bb3_pkg::PIX_W-1:0] new_col;
  logic [bb3_pkg::SUM_W-1:0]      sum;
  logic [2*bb3_pkg::SUM_W-1:0]    prod;

  assign new_col = {px_i, up1_i, up2_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q   <= '0;
      right_q <= '0;
    end else if (shift_i) begin
      mid_q   <= right_q;
      right_q <= new_col;
    end
  end

  // window after the shift: mid, right, new column
  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      sum = sum + bb3_pkg::SUM_W'(mid_q[r]) + bb3_pkg::SUM_W'(right_q[r])
                + bb3_pkg::SUM_W'(new_col[r]);
    end
  end

  assign prod   = sum * bb3_pkg::DIV9_MUL;
  assign mean_o = prod[bb3_pkg::DIV9_SHIFT +: bb3_pkg::PIX_W];

endmodule

[src/box_blur_3x3.sv]
// 3x3 box blur: takes one 8-bit sample per clock in raster order while in_stall_o
// is low and returns the truncated mean of each interior pixel's 3x3 neighborhood;
// border pixels give no result, and frame_last_o marks the final interior pixel.
// Throughput is one pixel per clock while not stalled, set by the single line-store
// RAM that is read at the accepting edge and written back when the beat leaves the
// input register; a pixel is registered in stage 1 and its result in the output
// register. A stalled result holds both stages, and in_stall_o rises only while
// both are full and the output is stalled. The line stores need no clearing pass
// after reset. The user writes the size registers via the cfg port (index 0 width,
// 1 height) only while the block is idle; the block itself does not enforce this.
// Sizes below 3 act as 3 and sizes above 1024 act as 1024.
// Depends on bb3_pkg, bb3_ram, bb3_pos and bb3_window.
module box_blur_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bb3_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bb3_pkg::PIX_W-1:0]     pixel_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bb3_pkg::PIX_W-1:0]     mean_value_o,
  output logic                          frame_last_o
);

  logic                          accept;
  logic                          s1_adv;
  logic [bb3_pkg::COL_W-1:0]     col;
  bb3_pkg::pos_t                 pos;

  logic                          s1_valid_q;
  logic [bb3_pkg::PIX_W-1:0]     s1_px_q;
  logic [bb3_pkg::COL_W-1:0]     s1_col_q;
  bb3_pkg::pos_t                 s1_pos_q;

  logic [bb3_pkg::LINE_W-1:0]    line_rdata, line_wdata;
  logic [bb3_pkg::PIX_W-1:0]     up1, up2, mean;

  logic                          out_valid_q;
  logic [bb3_pkg::PIX_W-1:0]     mean_q;
  logic                          last_q;

  assign cfg_ready_o = 1'b1;

  // stage 1 moves on when the result register is free or being drained
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  bb3_pos u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .col_o       (col),
    .pos_o       (pos)
  );

  // low byte: previous line, high byte: line before that
  assign up1        = line_rdata[bb3_pkg::PIX_W-1:0];
  assign up2        = line_rdata[bb3_pkg::LINE_W-1:bb3_pkg::PIX_W];
  assign line_wdata = {up1, s1_px_q};

  // consecutive beats always hit different columns, so read and write never collide
  bb3_ram #(
    .Width (bb3_pkg::LINE_W),
    .Depth (bb3_pkg::MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (line_wdata),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (line_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept || s1_adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q  <= pixel_value_i;
      s1_col_q <= col;
      s1_pos_q <= pos;
    end
  end

  bb3_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(s1_valid_q && s1_adv),
    .up2_i  (up2),
    .up1_i  (up1),
    .px_i   (s1_px_q),
    .mean_o (mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q && s1_pos_q.produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      mean_q <= mean;
      last_q <= s1_pos_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_value_o = mean_q;
  assign frame_last_o = last_q;

endmodule

[test/box_blur_3x3_tb.sv]
// Self-checking testbench for box_blur_3x3: a raster pixel stream goes in, and every
// 3x3 mean that comes out is checked against a predictor that is updated on each accepted beat.
// Depends on bb3_pkg and the box_blur_3x3 RTL only.
`timescale 1ns / 1ps

module box_blur_3x3_tb;

  localparam int LIMIT_CYCLES = 500_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PIXELS = 650;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_HIGH, MIX_LOW} pixel_mix_e;

  typedef struct packed {
    logic [bb3_pkg::PIX_W-1:0] mean_value;
    logic                      frame_last;
  } mean_item_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bb3_pkg::DIM_W-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [bb3_pkg::PIX_W-1:0]     pixel_value_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [bb3_pkg::PIX_W-1:0]     mean_value_o;
  logic                          frame_last_o;

  box_blur_3x3 DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: size registers, line stores, window and raster position
  logic [bb3_pkg::DIM_W-1:0] width_reg = bb3_pkg::DIM_RESET;
  logic [bb3_pkg::DIM_W-1:0] height_reg = bb3_pkg::DIM_RESET;
  logic [bb3_pkg::PIX_W-1:0] prev_line [bb3_pkg::MAX_WIDTH];
  logic [bb3_pkg::PIX_W-1:0] prev_prev_line [bb3_pkg::MAX_WIDTH];
  logic [bb3_pkg::PIX_W-1:0] blur_window [9] = '{default: '0};
  int                        raster_col = 0;
  int                        raster_row = 0;

  mean_item_t                mean_expect_q [$];
  logic [bb3_pkg::PIX_W-1:0] pixel_queue [$];

  idle_mode_e idle_mode = IDLE_NONE;
  int error_count = 0;
  int pixels_accepted = 0;
  int means_checked = 0;
  int frames_closed = 0;
  int reg_writes = 0;
  int random_items = 0;
  int phase_count = 0;
  int cycle_count = 0;

  function automatic int eff_dim(logic [bb3_pkg::DIM_W-1:0] v, int maxv);
    if (v < bb3_pkg::MIN_DIM) return int'(bb3_pkg::MIN_DIM);
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // advance the predictor by one accepted pixel
  task automatic box_mean_step(input logic [bb3_pkg::PIX_W-1:0] px);
    int w, h, sum;
    bit last_col, last_row;
    logic [bb3_pkg::PIX_W-1:0] up1, up2;
    mean_item_t want;
    w = eff_dim(width_reg, bb3_pkg::MAX_WIDTH);
    h = eff_dim(height_reg, bb3_pkg::MAX_HEIGHT);
    last_col = (raster_col + 1 >= w);
    last_row = (raster_row + 1 >= h);
    up1 = prev_line[raster_col];
    up2 = prev_prev_line[raster_col];
    prev_prev_line[raster_col] = up1;
    prev_line[raster_col] = px;
    for (int r = 0; r < 3; r++) begin
      blur_window[r*3] = blur_window[r*3+1];
      blur_window[r*3+1] = blur_window[r*3+2];
    end
    blur_window[2] = up2;
    blur_window[5] = up1;
    blur_window[8] = px;
    if (raster_col >= 2 && raster_row >= 2) begin
      sum = 0;
      for (int i = 0; i < 9; i++) sum += int'(blur_window[i]);
      want.mean_value = bb3_pkg::PIX_W'(sum / 9);
      want.frame_last = last_col && last_row;
      mean_expect_q.push_back(want);
    end
    if (last_col) begin
      raster_col = 0;
      raster_row = last_row ? 0 : raster_row + 1;
    end else begin
      raster_col++;
    end
  endtask

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 72;
      IDLE_BOTH: return $urandom_range(0, 99) < 34;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 72;
      IDLE_BOTH: return $urandom_range(0, 99) < 34;
      default:   return 1'b0;
    endcase
  endfunction

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic hold_beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      pixel_value_i <= '0;
    end else begin
      hold_beat = in_valid_i && in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        box_mean_step(pixel_value_i);
        pixels_accepted++;
      end
      if (!hold_beat) begin
        if (pixel_queue.size() > 0 && !sender_gap()) begin
          in_valid_i <= 1'b1;
          pixel_value_i <= pixel_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    mean_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (mean_expect_q.size() == 0) begin
          $error("unexpected beat: mean_value %0d frame_last %0b", mean_value_o, frame_last_o);
          error_count++;
        end else begin
          want = mean_expect_q.pop_front();
          if (mean_value_o !== want.mean_value) begin
            $error("mean_value: expected %0d, got %0d", want.mean_value, mean_value_o);
            error_count++;
          end
          if (frame_last_o !== want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, frame_last_o);
            error_count++;
          end
          means_checked++;
          if (want.frame_last) frames_closed++;
        end
      end
      out_stall_i <= receiver_stall();
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** box_blur_3x3: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input bb3_pkg::cfg_idx_e idx,
                           input logic [bb3_pkg::DIM_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == bb3_pkg::CFG_IMAGE_WIDTH) width_reg = data;
    else height_reg = data;
    reg_writes++;
  endtask

  // sender holds off until every queued pixel is in and every mean is out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || in_valid_i || mean_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pixels_to_frame_end();
    int c, r, w, h, n;
    bit done;
    c = raster_col;
    r = raster_row;
    w = eff_dim(width_reg, bb3_pkg::MAX_WIDTH);
    h = eff_dim(height_reg, bb3_pkg::MAX_HEIGHT);
    n = 0;
    done = 1'b0;
    while (!done) begin
      n++;
      if (c + 1 >= w) begin
        if (r + 1 >= h) done = 1'b1;
        c = 0;
        r++;
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  function automatic logic [bb3_pkg::PIX_W-1:0] next_pixel(pixel_mix_e mix);
    case (mix)
      MIX_EXTREME: return ($urandom_range(0, 99) < 85) ? 8'hFF : 8'h00;
      MIX_HIGH:    return bb3_pkg::PIX_W'($urandom_range(240, 255));
      MIX_LOW:     return bb3_pkg::PIX_W'($urandom_range(0, 2));
      default:     return bb3_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixels(input int n, input pixel_mix_e mix);
    repeat (n) pixel_queue.push_back(next_pixel(mix));
  endtask

  task automatic random_phase();
    int n, w, h;
    pixel_mix_e mix;
    idle_mode = idle_mode_e'(phase_count % 4);
    phase_count++;
    if ($urandom_range(0, 99) < 60) begin
      if (raster_col == 0 && raster_row == 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::DIM_W'($urandom_range(0, 2)));
          1:       write_reg(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::DIM_W'($urandom_range(13, 40)));
          default: write_reg(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::DIM_W'($urandom_range(3, 12)));
        endcase
        case ($urandom_range(0, 9))
          0:       write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::DIM_W'($urandom_range(0, 2)));
          1:       write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::DIM_W'($urandom_range(9, 20)));
          default: write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::DIM_W'($urandom_range(3, 8)));
        endcase
      end else begin
        // inside a frame the width only shrinks, so no line store entry is read unwritten
        if ($urandom_range(0, 1))
          write_reg(bb3_pkg::CFG_IMAGE_WIDTH,
                    bb3_pkg::DIM_W'($urandom_range(0, eff_dim(width_reg, bb3_pkg::MAX_WIDTH))));
        write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::DIM_W'($urandom_range(0, 10)));
      end
    end
    mix = pixel_mix_e'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 70) begin
      w = eff_dim(width_reg, bb3_pkg::MAX_WIDTH);
      h = eff_dim(height_reg, bb3_pkg::MAX_HEIGHT);
      n = pixels_to_frame_end();
      if (w * h <= 100) n += int'($urandom_range(0, 2)) * w * h;
    end else begin
      n = int'($urandom_range(1, 120));
    end
    push_pixels(n, mix);
    random_items += n;
    wait_drained();
  endtask

  // from a frame start: a width above the maximum acts as 1024, so one full line
  // wraps the row; then the width shrinks mid-line and the frame closes at 3x3
  task automatic wide_line_check();
    idle_mode = idle_mode_e'(phase_count % 4);
    phase_count++;
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 11'd2047);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 11'd1);
    push_pixels(bb3_pkg::MAX_WIDTH + 3, MIX_UNIFORM);
    wait_drained();
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 11'd3);
    push_pixels(4, MIX_UNIFORM);
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size: part of the first line, then the width shrinks mid-line
    idle_mode = IDLE_NONE;
    pixel_queue = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
    wait_drained();
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 11'd2);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 11'd3);
    // column past the new width wraps; the one mean truncates 2294/9 down to 254
    pixel_queue = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254};
    wait_drained();
    // smallest frame, height written as zero; all-white gives the top mean
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 11'd3);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 11'd0);
    repeat (9) pixel_queue.push_back(8'd255);
    wait_drained();

    wide_line_check();
    while (random_items < RANDOM_PIXELS) random_phase();

    $display("Run: %0d pixels in, %0d means checked over %0d closed frames, %0d size writes",
             pixels_accepted, means_checked, frames_closed, reg_writes);
    $display("Sizes from the 3x3 floor to a clamped 1024-pixel line, under %0d stall phases",
             phase_count);
    if (error_count == 0) begin
      $display("** box_blur_3x3: PASSED **");
    end else begin
      $display("** box_blur_3x3: FAILED **");
    end
    $finish;
  end

endmodule
